[design/tldd_pkg.sv]
// Package for the tile-layer data decoder: status codes, character constants,
// the result record types and the base64 alphabet lookup.
// No dependencies; every design file imports it.
package tldd_pkg;

    // Result status codes.
    localparam logic [2:0] ST_VALUE    = 3'd0;
    localparam logic [2:0] ST_END_OK   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_PARTIAL  = 3'd4;

    // Encoding register values.
    localparam logic MODE_CSV = 1'b0;
    localparam logic MODE_B64 = 1'b1;

    // Character codes used by both decoders.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PAD   = 8'h3d;

    // Sextet offsets of the lowercase and digit ranges, and the two symbols.
    localparam logic [5:0] SX_LOWER = 6'h1a;
    localparam logic [5:0] SX_DIGIT = 6'h34;
    localparam logic [5:0] SX_PLUS  = 6'h3e;
    localparam logic [5:0] SX_SLASH = 6'h3f;

    // Depth of the result queue.
    localparam int QUEUE_DEPTH = 4;

    // What one decoder reports for one character.
    typedef struct packed {
        logic        val_valid;  // a tile id is produced
        logic [31:0] val_id;
        logic [2:0]  err;        // error raised, ST_VALUE when none
    } unit_res_t;

    // One result item.
    typedef struct packed {
        logic [31:0] tile_id;
        logic [2:0]  status;
        logic        is_last;
    } result_t;

    // Base64 alphabet lookup; bit 6 set when the character is in the alphabet or is the pad character.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = {1'b1, 6'(c - CH_UP_A)};
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            r = {1'b1, 6'(c - CH_LO_A) + SX_LOWER};
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 6'(c - CH_ZERO) + SX_DIGIT};
        end else if (c == CH_PLUS) begin
            r = {1'b1, SX_PLUS};
        end else if (c == CH_SLASH) begin
            r = {1'b1, SX_SLASH};
        end else if (c == CH_PAD) begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

endpackage

[design/tile_layer_data_decoder.sv]
// Tile-layer data decoder top level: mode register, sticky error and result
// ordering. Depends on tldd_pkg, tldd_csv, tldd_b64 and tldd_outq.
//
// Usage: text characters arrive on the s_ stream, one per transfer, with
// s_tlast on the final character of a stream. cfg_wen/cfg_wdata select the
// encoding (0 comma separated decimal, 1 base64 little-endian words) and must
// be written only between streams; the block itself does not enforce this.
// Each result on the m_ stream carries a tile id in m_tdata, a status code in
// m_tuser and m_tlast on the end-of-stream result.
// Throughput: one character per cycle. A character produces zero, one or two
// results; the decoders finish it in the accept cycle and the results land in
// a four-entry result queue, so the first result is visible in the cycle after
// the character transfer. s_tready drops while the queue holds more than two
// results, which is what limits the input rate when the receiver stalls or a
// character yields two results.
// Reset clears the decoders, the sticky error, the queue and selects
// comma separated mode.
module tile_layer_data_decoder import tldd_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,   // encoding_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_code
    input  logic        s_tlast,     // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] tile_id
    output logic [2:0]  m_tuser,     // [2:0] status
    output logic        m_tlast      // is_last
);

    logic       mode_reg;
    logic [2:0] sticky_reg, sticky_next;

    logic       s_xfer, active, csv_step, b64_step, clear;
    unit_res_t  csv_res, b64_res, sel_res;
    logic [2:0] err_now;
    logic       val_now, has_second;
    result_t    val_item, second_item, e0, e1;
    logic [1:0] push_cnt;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CSV;
        end else if (cfg_wen) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Characters are decoded only while no error is pending.
    always_comb begin
        s_xfer   = s_tvalid && s_tready;
        active   = s_xfer && (sticky_reg == ST_VALUE);
        csv_step = active && (mode_reg == MODE_CSV);
        b64_step = active && (mode_reg == MODE_B64);
        clear    = s_xfer && s_tlast;
    end

    tldd_csv u_csv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (csv_step),
        .clear     (clear),
        .char_code (s_tdata),
        .at_end    (s_tlast),
        .res       (csv_res)
    );

    tldd_b64 u_b64 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (b64_step),
        .clear     (clear),
        .char_code (s_tdata),
        .at_end    (s_tlast),
        .res       (b64_res)
    );

    // Order the results: a value first, then an error or the end result.
    always_comb begin
        sel_res = (mode_reg == MODE_B64) ? b64_res : csv_res;
        err_now = active ? sel_res.err : ST_VALUE;
        val_now = active && sel_res.val_valid;

        val_item         = '0;
        val_item.tile_id = sel_res.val_id;
        val_item.status  = ST_VALUE;

        second_item = '0;
        has_second  = 1'b0;
        if (clear) begin
            has_second          = 1'b1;
            second_item.is_last = 1'b1;
            if (sticky_reg != ST_VALUE) begin
                second_item.status = sticky_reg;
            end else if (err_now != ST_VALUE) begin
                second_item.status = err_now;
            end else begin
                second_item.status = ST_END_OK;
            end
        end else if (err_now != ST_VALUE) begin
            has_second         = 1'b1;
            second_item.status = err_now;
        end

        if (val_now) begin
            e0       = val_item;
            e1       = second_item;
            push_cnt = has_second ? 2'd2 : 2'd1;
        end else begin
            e0       = second_item;
            e1       = second_item;
            push_cnt = has_second ? 2'd1 : 2'd0;
        end

        sticky_next = sticky_reg;
        if (clear) begin
            sticky_next = ST_VALUE;
        end else if (err_now != ST_VALUE) begin
            sticky_next = err_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_reg <= ST_VALUE;
        end else begin
            sticky_reg <= sticky_next;
        end
    end

    tldd_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .e0       (e0),
        .e1       (e1),
        .space_ok (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[design/tldd_csv.sv]
// Comma separated decimal decoder: accumulator, digit flag and the per-character
// decision. Depends on tldd_pkg.
module tldd_csv import tldd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,       // character transfer taken by this decoder
    input  logic       clear,      // end of stream clears all state
    input  logic [7:0] char_code,
    input  logic       at_end,
    output unit_res_t  res
);

    logic [31:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;

    logic        is_digit, is_comma;
    logic [35:0] mac;
    logic [31:0] acc_mid;
    logic        seen_mid;

    // Per-character decision, then the closing of the last field at the end.
    always_comb begin
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_comma = (char_code == CH_COMMA);
        mac      = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                 + {32'd0, char_code[3:0]};
        res      = '0;
        acc_mid  = acc_reg;
        seen_mid = seen_reg;
        if (is_digit) begin
            if (mac[35:32] != 4'd0) begin
                res.err = ST_OVERFLOW;
            end else begin
                acc_mid  = mac[31:0];
                seen_mid = 1'b1;
            end
        end else if (is_comma) begin
            if (seen_reg) begin
                res.val_valid = 1'b1;
                res.val_id    = acc_reg;
                acc_mid       = 32'd0;
                seen_mid      = 1'b0;
            end else begin
                res.err = ST_EMPTY;
            end
        end
        // The final field closes as if a comma followed.
        if (at_end && res.err == ST_VALUE) begin
            if (seen_mid) begin
                res.val_valid = 1'b1;
                res.val_id    = acc_mid;
            end else begin
                res.err = ST_EMPTY;
            end
        end
    end

    // State update.
    always_comb begin
        acc_next  = acc_reg;
        seen_next = seen_reg;
        if (clear) begin
            acc_next  = 32'd0;
            seen_next = 1'b0;
        end else if (step) begin
            acc_next  = acc_mid;
            seen_next = seen_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= 32'd0;
            seen_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[design/tldd_b64.sv]
// Base64 decoder: sextet group, byte assembly and little-endian word packing.
// Depends on tldd_pkg.
module tldd_b64 import tldd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       clear,
    input  logic [7:0] char_code,
    input  logic       at_end,
    output unit_res_t  res
);

    logic [23:0] grp_reg, grp_next;
    logic [1:0]  scnt_reg, scnt_next;
    logic [23:0] asm_reg, asm_next;
    logic [1:0]  bcnt_reg, bcnt_next;

    logic [6:0]  sx;
    logic [23:0] grp_sh;
    logic [7:0]  b2, b1, b0;
    logic [23:0] grp_mid, asm_mid;
    logic [1:0]  scnt_mid, bcnt_mid;

    // Sextet shift-in; a full group pushes three bytes into the word.
    always_comb begin
        sx       = sextet_of(char_code);
        grp_sh   = {grp_reg[17:0], sx[5:0]};
        b2       = grp_sh[23:16];
        b1       = grp_sh[15:8];
        b0       = grp_sh[7:0];
        res      = '0;
        grp_mid  = grp_reg;
        scnt_mid = scnt_reg;
        asm_mid  = asm_reg;
        bcnt_mid = bcnt_reg;
        if (sx[6]) begin
            if (scnt_reg == 2'd3) begin
                grp_mid  = 24'd0;
                scnt_mid = 2'd0;
                case (bcnt_reg)
                    2'd0: begin
                        asm_mid  = {b0, b1, b2};
                        bcnt_mid = 2'd3;
                    end
                    2'd1: begin
                        res.val_valid = 1'b1;
                        res.val_id    = {b0, b1, b2, asm_reg[7:0]};
                        asm_mid       = 24'd0;
                        bcnt_mid      = 2'd0;
                    end
                    2'd2: begin
                        res.val_valid = 1'b1;
                        res.val_id    = {b1, b2, asm_reg[15:0]};
                        asm_mid       = {16'd0, b0};
                        bcnt_mid      = 2'd1;
                    end
                    default: begin
                        res.val_valid = 1'b1;
                        res.val_id    = {b2, asm_reg};
                        asm_mid       = {8'd0, b0, b1};
                        bcnt_mid      = 2'd2;
                    end
                endcase
            end else begin
                grp_mid  = grp_sh;
                scnt_mid = scnt_reg + 2'd1;
            end
        end
        // A partial group or word left at the end is an error.
        if (at_end && (scnt_mid != 2'd0 || bcnt_mid != 2'd0)) begin
            res.err = ST_PARTIAL;
        end
    end

    // State update.
    always_comb begin
        grp_next  = grp_reg;
        scnt_next = scnt_reg;
        asm_next  = asm_reg;
        bcnt_next = bcnt_reg;
        if (clear) begin
            grp_next  = 24'd0;
            scnt_next = 2'd0;
            asm_next  = 24'd0;
            bcnt_next = 2'd0;
        end else if (step) begin
            grp_next  = grp_mid;
            scnt_next = scnt_mid;
            asm_next  = asm_mid;
            bcnt_next = bcnt_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg  <= 24'd0;
            scnt_reg <= 2'd0;
            asm_reg  <= 24'd0;
            bcnt_reg <= 2'd0;
        end else begin
            grp_reg  <= grp_next;
            scnt_reg <= scnt_next;
            asm_reg  <= asm_next;
            bcnt_reg <= bcnt_next;
        end
    end

endmodule

[design/tldd_outq.sv]
// Result queue: takes up to two results per cycle and presents one per cycle
// on the output stream while the receiver is ready. Depends on tldd_pkg.
module tldd_outq import tldd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  push_cnt,   // results written this cycle, in order
    input  result_t     e0,
    input  result_t     e1,
    output logic        space_ok,   // room for the two results of one item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         q_mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   wr_ptr_p1;
    logic            pop;
    result_t         head;

    // Head of queue drives the output stream.
    always_comb begin
        head     = q_mem[rd_ptr_reg];
        m_tvalid = (count_reg != '0);
        m_tdata  = head.tile_id;
        m_tuser  = head.status;
        m_tlast  = head.is_last;
        pop      = m_tvalid && m_tready;
        space_ok = (count_reg <= CW'(DEPTH - 2));
    end

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_p1   = AW'((DEPTH == (1 << AW)) ? wr_ptr_reg + 1'b1
                      : ((32'(wr_ptr_reg) == DEPTH - 1) ? 0 : wr_ptr_reg + 1'b1));
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1) begin
            wr_ptr_next = wr_ptr_p1;
        end else if (push_cnt == 2'd2) begin
            wr_ptr_next = AW'((32'(wr_ptr_p1) == DEPTH - 1) ? 0 : 32'(wr_ptr_p1) + 1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = AW'((32'(rd_ptr_reg) == DEPTH - 1) ? 0 : 32'(rd_ptr_reg) + 1);
        end
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, no reset needed.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= e0;
        end
        if (push_cnt == 2'd2) begin
            q_mem[wr_ptr_p1] <= e1;
        end
    end

endmodule

[design/tldd_checker.sv]
// Port-level checker for the tile-layer data decoder and its bind statement.
// Depends on tldd_pkg and tile_layer_data_decoder.
module tldd_checker import tldd_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Only value results carry a tile id.
    a_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_VALUE |-> m_tdata == 32'd0)
        else $error("non-value result with nonzero id");

    // The end-of-stream result never carries a value status.
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser != ST_VALUE)
        else $error("end result with value status");

    // End-ok status appears only on the end-of-stream result.
    a_end_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser != ST_END_OK)
        else $error("end-ok status before end of stream");

    // Reset empties the result queue.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tile_layer_data_decoder tldd_checker u_tldd_checker (.*);

[tb/sv/tb_tile_layer_data_decoder.sv]
// Self-checking testbench for the tile-layer data decoder: directed text, then random
// CSV and base64 streams under several idle and stall patterns, checked by a predictor.
// Depends on tldd_pkg and tile_layer_data_decoder.
module tb_tile_layer_data_decoder;
    import tldd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 4000;
    localparam int N_DIRECTED    = 29;
    localparam int PHASE_CHARS   = 120;
    localparam int MAX_REPORTS   = 10;

    // One directed character; want holds a result typed in by hand when typed is set.
    typedef struct packed {
        logic        mode;
        logic [7:0]  ch;
        logic        eod;
        logic        typed;
        result_t     want;
    } text_row_t;

    localparam result_t NO_TYPED = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int bad_count = 0;
    int quiet_cycles = 0;

    // Expected results in arrival order, and those of the last character.
    result_t ids_due[$];
    result_t step_res[$];
    logic [7:0] line_q[$];

    // Predictor state.
    logic        p_mode;
    logic [31:0] p_acc;
    logic        p_digit;
    logic [23:0] p_group;
    logic [1:0]  p_nsext;
    logic [23:0] p_bytes;
    logic [1:0]  p_nbytes;
    logic [2:0]  p_err;

    // Directed text: CSV corner cases, a base64 group split over a word, and a
    // mode change in the middle of a stream.
    text_row_t script [N_DIRECTED] = '{
        '{MODE_CSV, CH_COMMA, 1'b0, 1'b1, '{32'd0, ST_EMPTY, 1'b0}},
        '{MODE_CSV, "x",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "5",      1'b1, 1'b1, '{32'd0, ST_EMPTY, 1'b1}},
        '{MODE_CSV, "7",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "a",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, 8'hb7,    1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "3",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, CH_COMMA, 1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "9",      1'b1, 1'b0, NO_TYPED},
        '{MODE_CSV, CH_COMMA, 1'b1, 1'b1, '{32'd0, ST_EMPTY, 1'b1}},
        '{MODE_CSV, "z",      1'b1, 1'b1, '{32'd0, ST_EMPTY, 1'b1}},
        '{MODE_CSV, "1",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, CH_COMMA, 1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, CH_COMMA, 1'b0, 1'b1, '{32'd0, ST_EMPTY, 1'b0}},
        '{MODE_CSV, 8'hff,    1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, 8'h00,    1'b1, 1'b1, '{32'd0, ST_EMPTY, 1'b1}},
        '{MODE_B64, "T",      1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, "W",      1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, "F",      1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, "u",      1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, "@",      1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, CH_PAD,   1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, CH_PLUS,  1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, CH_SLASH, 1'b0, 1'b0, NO_TYPED},
        '{MODE_B64, "z",      1'b1, 1'b0, NO_TYPED},
        '{MODE_B64, "Q",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "1",      1'b0, 1'b0, NO_TYPED},
        '{MODE_CSV, "2",      1'b1, 1'b0, NO_TYPED},
        '{MODE_B64, "Q",      1'b1, 1'b1, '{32'd0, ST_PARTIAL, 1'b1}}
    };

    tile_layer_data_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Receiver stalls at random, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    // Base64 alphabet value; bit 6 marks a character inside the alphabet or the pad character.
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
        if (c == CH_PLUS) return {1'b1, 6'd62};
        if (c == CH_SLASH) return {1'b1, 6'd63};
        if (c == CH_PAD) return {1'b1, 6'd0};
        return 7'd0;
    endfunction

    // An error is remembered; it is reported on its own only before the last character.
    function automatic void raise_status(input logic [2:0] code, input logic eod);
        p_err = code;
        if (!eod) step_res.push_back('{32'd0, code, 1'b0});
    endfunction

    function automatic void close_field(input logic eod);
        if (!p_digit) begin
            raise_status(ST_EMPTY, eod);
        end else begin
            step_res.push_back('{p_acc, ST_VALUE, 1'b0});
            p_acc = '0;
            p_digit = 1'b0;
        end
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        if (p_nbytes == 2'd3) begin
            step_res.push_back('{{b, p_bytes}, ST_VALUE, 1'b0});
            p_bytes = '0;
            p_nbytes = '0;
        end else begin
            p_bytes[8 * p_nbytes +: 8] = b;
            p_nbytes = p_nbytes + 2'd1;
        end
    endfunction

    // Works out the results of one accepted character into step_res.
    function automatic void decode_char(input logic [7:0] c, input logic eod);
        logic [63:0] grown;
        logic [6:0]  sx;
        step_res.delete();
        if (p_err == ST_VALUE) begin
            if (p_mode == MODE_CSV) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    grown = 64'(p_acc) * 64'd10 + 64'(c - CH_ZERO);
                    if (grown > 64'hffff_ffff) begin
                        raise_status(ST_OVERFLOW, eod);
                    end else begin
                        p_acc = grown[31:0];
                        p_digit = 1'b1;
                    end
                end else if (c == CH_COMMA) begin
                    close_field(eod);
                end
            end else begin
                sx = b64_value(c);
                if (sx[6]) begin
                    p_group = {p_group[17:0], sx[5:0]};
                    if (p_nsext == 2'd3) begin
                        p_nsext = '0;
                        take_byte(p_group[23:16]);
                        take_byte(p_group[15:8]);
                        take_byte(p_group[7:0]);
                        p_group = '0;
                    end else begin
                        p_nsext = p_nsext + 2'd1;
                    end
                end
            end
        end
        // The end of a stream closes the open field, checks for a partial group and clears everything.
        if (eod) begin
            if (p_err == ST_VALUE) begin
                if (p_mode == MODE_CSV)
                    close_field(1'b1);
                else if (p_nsext != 0 || p_nbytes != 0)
                    raise_status(ST_PARTIAL, 1'b1);
            end
            step_res.push_back('{32'd0, (p_err != ST_VALUE) ? p_err : ST_END_OK, 1'b1});
            p_acc = '0;
            p_digit = 1'b0;
            p_group = '0;
            p_nsext = '0;
            p_bytes = '0;
            p_nbytes = '0;
            p_err = ST_VALUE;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 6'd62) ? CH_PLUS : CH_SLASH;
    endfunction

    // A character that the decoder of the given mode drops.
    function automatic logic [7:0] noise_char(input logic m);
        logic [7:0] c;
        logic       kept;
        kept = 1'b1;
        while (kept) begin
            c = 8'($urandom_range(0, 255));
            if (m == MODE_CSV) begin
                kept = (c >= CH_ZERO && c <= CH_NINE) || c == CH_COMMA;
            end else begin
                kept = b64_value(c) != 7'd0;
            end
        end
        return c;
    endfunction

    function automatic void put_char(input logic [7:0] c, input logic m);
        line_q.push_back(c);
        if ($urandom_range(0, 19) == 0) line_q.push_back(noise_char(m));
    endfunction

    function automatic void put_decimal(input logic [63:0] v);
        logic [7:0] digs[$];
        if ($urandom_range(0, 7) == 0) digs.push_back(CH_ZERO);
        do begin
            digs.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[i]) put_char(digs[i], MODE_CSV);
    endfunction

    // Mostly well-formed comma separated fields, with extremes and overflowing values.
    function automatic void build_csv_text();
        int          nf;
        logic [63:0] v;
        line_q.delete();
        if ($urandom_range(0, 99) < 85) begin
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++) begin
                case ($urandom_range(0, 5))
                    0: v = 64'($urandom_range(0, 9));
                    1: v = 64'($urandom);
                    2: v = 64'hffff_ffff;
                    3: v = 64'h1_0000_0000 + 64'($urandom_range(0, 3));
                    4: v = {$urandom, $urandom};
                    default: v = 64'($urandom_range(0, 99999));
                endcase
                put_decimal(v);
                if (f != nf - 1) put_char(CH_COMMA, MODE_CSV);
            end
            if ($urandom_range(0, 9) == 0) line_q.push_back(CH_COMMA);
        end else begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0, 1: line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    2: line_q.push_back(CH_COMMA);
                    default: line_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endfunction

    // Mostly whole 16-character blocks (twelve bytes, three words), else cut-off text.
    function automatic void build_b64_text();
        line_q.delete();
        if ($urandom_range(0, 99) < 80) begin
            repeat (16 * $urandom_range(1, 3)) begin
                if ($urandom_range(0, 11) == 0)
                    put_char(CH_PAD, MODE_B64);
                else
                    put_char(b64_char(6'($urandom_range(0, 63))), MODE_B64);
            end
        end else begin
            repeat ($urandom_range(1, 20)) begin
                if ($urandom_range(0, 3) == 0)
                    line_q.push_back(8'($urandom_range(0, 255)));
                else
                    line_q.push_back(b64_char(6'($urandom_range(0, 63))));
            end
        end
    endfunction

    // Offers one character, waits for its transfer and records what it should yield.
    task automatic send_char(input logic [7:0] c, input logic eod);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eod;
        do @(posedge aclk); while (!s_tready);
        decode_char(c, eod);
        foreach (step_res[i]) ids_due.push_back(step_res[i]);
    endtask

    // The mode is changed only once every result has come and the block has settled.
    task automatic set_mode(input logic m);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ids_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        p_mode = m;
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser, m_tlast};
            if (ids_due.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("Unexpected result: id %0d status %0d last %0d",
                             got.tile_id, got.status, got.is_last);
            end else begin
                want = ids_due.pop_front();
                if (got !== want) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("Mismatch: expected id %0d status %0d last %0d,",
                                 want.tile_id, want.status, want.is_last,
                                 " got id %0d status %0d last %0d",
                                 got.tile_id, got.status, got.is_last);
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int sent;
        p_mode = MODE_CSV;
        p_acc = '0;
        p_digit = 1'b0;
        p_group = '0;
        p_nsext = '0;
        p_bytes = '0;
        p_nbytes = '0;
        p_err = ST_VALUE;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed text; a typed row replaces what the predictor worked out.
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (i == 0 || script[i].mode != p_mode) set_mode(script[i].mode);
            send_char(script[i].ch, script[i].eod);
            if (script[i].typed) begin
                repeat (step_res.size()) void'(ids_due.pop_back());
                ids_due.push_back(script[i].want);
            end
        end

        // Random streams: each idle pattern once per mode.
        for (int p = 0; p < 8; p++) begin
            set_mode(logic'(p % 2));
            case (p / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            sent = 0;
            while (sent < PHASE_CHARS) begin
                if (p_mode == MODE_CSV) build_csv_text();
                else build_b64_text();
                foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
                sent += line_q.size();
            end
        end

        // Drain the remaining results, then wait for stray ones.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (ids_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (bad_count == 0 && ids_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
